// ===== rtl/rrb_pkg.sv =====
package rrb_pkg;

    // Input function codes.
    localparam logic FUNC_STORE = 1'b0;
    localparam logic FUNC_READ  = 1'b1;

    // Flow control modes.
    localparam logic FLOW_RTS     = 1'b0;
    localparam logic FLOW_XONXOFF = 1'b1;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;
    localparam logic [CFG_INDEX_W-1:0] CFG_FLOW_MODE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HIGH_WATER = 2'd1;

    // Reset values of the configuration registers.
    localparam logic       FLOW_MODE_RESET  = FLOW_RTS;
    localparam logic [7:0] HIGH_WATER_RESET = 8'd64;

    // Flow control characters.
    localparam logic [7:0] XON_CHAR  = 8'h11;
    localparam logic [7:0] XOFF_CHAR = 8'h13;

    // Controller states.
    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic load_out;
    } rrb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_valid;
    } rrb_status_t;

endpackage

// ===== rtl/rrb_ctrl.sv =====
module rrb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               out_ready,
    input  rrb_pkg::rrb_status_t status,
    output rrb_pkg::rrb_cmd_t    cmd
);
    import rrb_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands. A transaction is taken in idle; the result is
    // loaded once the output register is free or being emptied.
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!status.out_valid || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rrb_datapath.sv =====
module rrb_datapath #(
    parameter int DEPTH = 128
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [rrb_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rrb_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                func,
    input  logic [7:0]                          rx_byte,
    input  logic                                out_ready,
    input  rrb_pkg::rrb_cmd_t                   cmd,
    output rrb_pkg::rrb_status_t                status,
    output logic                                out_valid,
    output logic [7:0]                          read_data,
    output logic                                read_valid,
    output logic                                rx_dropped,
    output logic                                rts_level,
    output logic                                send_char_valid,
    output logic [7:0]                          send_char
);
    import rrb_pkg::*;

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > 8) ? CW : 8;
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    // Configuration registers.
    logic       flow_mode_reg;
    logic [7:0] high_water_reg;

    // FIFO control state.
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          paused_reg, paused_next;
    logic          rts_reg, rts_next;

    // Flags of the transaction in flight, waiting for the memory read.
    logic       pend_rd_valid_reg;
    logic       pend_dropped_reg;
    logic       pend_rts_reg;
    logic       pend_sc_valid_reg;
    logic [7:0] pend_sc_reg;
    logic       rd_valid_c, dropped_c, sc_valid_c;
    logic [7:0] sc_c;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_rd_valid_reg;
    logic       out_dropped_reg;
    logic       out_rts_reg;
    logic       out_sc_valid_reg;
    logic [7:0] out_sc_reg;

    // Storage.
    logic [7:0] mem [DEPTH];
    logic [7:0] mem_q;
    logic       mem_we;
    logic       mem_re;

    logic store_op;
    logic read_op;
    logic above_mark;
    logic full;
    logic empty;

    assign store_op   = cmd.accept && (func == FUNC_STORE);
    assign read_op    = cmd.accept && (func == FUNC_READ);
    assign full       = (fill_reg == FULL_CNT);
    assign empty      = (fill_reg == '0);
    assign above_mark = CMPW'(fill_reg) > CMPW'(high_water_reg);
    assign mem_we     = store_op && !full;
    assign mem_re     = read_op && !empty;

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flow_mode_reg  <= FLOW_MODE_RESET;
            high_water_reg <= HIGH_WATER_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FLOW_MODE)
            begin
                flow_mode_reg <= cfg_data[0];
            end
            else if (cfg_index == CFG_HIGH_WATER)
            begin
                high_water_reg <= cfg_data;
            end
        end
    end

    // Pointer, fill count and flow control update for one transaction.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        paused_next = paused_reg;
        rts_next    = rts_reg;
        rd_valid_c  = 1'b0;
        dropped_c   = 1'b0;
        sc_valid_c  = 1'b0;
        sc_c        = 8'h00;
        if (store_op)
        begin
            if (above_mark)
            begin
                if (flow_mode_reg == FLOW_RTS)
                begin
                    rts_next = 1'b0;
                end
                else
                begin
                    sc_valid_c = 1'b1;
                    sc_c       = XOFF_CHAR;
                end
                paused_next = 1'b1;
            end
            if (!full)
            begin
                fill_next   = fill_reg + 1'b1;
                wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
            end
            else
            begin
                dropped_c = 1'b1;
            end
        end
        else if (read_op)
        begin
            if (!empty)
            begin
                rd_valid_c  = 1'b1;
                fill_next   = fill_reg - 1'b1;
                rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
            end
            else if (paused_reg)
            begin
                if (flow_mode_reg == FLOW_RTS)
                begin
                    rts_next = 1'b1;
                end
                else
                begin
                    sc_valid_c = 1'b1;
                    sc_c       = XON_CHAR;
                end
                paused_next = 1'b0;
            end
        end
    end

    // Control state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
            paused_reg <= 1'b0;
            rts_reg    <= 1'b1;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
            paused_reg <= paused_next;
            rts_reg    <= rts_next;
        end
    end

    // Flags held while the memory read completes.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            pend_rd_valid_reg <= rd_valid_c;
            pend_dropped_reg  <= dropped_c;
            pend_rts_reg      <= rts_next;
            pend_sc_valid_reg <= sc_valid_c;
            pend_sc_reg       <= sc_c;
        end
    end

    // Byte storage with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_ptr_reg] <= rx_byte;
        end
        if (mem_re)
        begin
            mem_q <= mem[rd_ptr_reg];
        end
    end

    // Output register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg     <= pend_rd_valid_reg ? mem_q : 8'h00;
            out_rd_valid_reg <= pend_rd_valid_reg;
            out_dropped_reg  <= pend_dropped_reg;
            out_rts_reg      <= pend_rts_reg;
            out_sc_valid_reg <= pend_sc_valid_reg;
            out_sc_reg       <= pend_sc_reg;
        end
    end

    assign status.out_valid = out_valid_reg;
    assign out_valid        = out_valid_reg;
    assign read_data        = out_data_reg;
    assign read_valid       = out_rd_valid_reg;
    assign rx_dropped       = out_dropped_reg;
    assign rts_level        = out_rts_reg;
    assign send_char_valid  = out_sc_valid_reg;
    assign send_char        = out_sc_reg;

    // The fill count never passes the depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FULL_CNT)
        else $error("fill count above depth");

    // An empty FIFO has both pointers at the same entry.
    a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("pointers differ while empty");

    // A presented result with no popped byte carries zero data.
    a_zero_data: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rd_valid_reg) |-> (out_data_reg == 8'h00))
        else $error("read data not zero without a pop");

    // A flow character is XON or XOFF, and zero when none is sent.
    a_flow_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_sc_valid_reg ?
            (out_sc_reg == XON_CHAR || out_sc_reg == XOFF_CHAR) :
            (out_sc_reg == 8'h00)))
        else $error("bad flow character");

endmodule

// ===== rtl/rx_ring_buffer_flow_control_top.sv =====
// Receive FIFO of DEPTH bytes with sender flow control. Each input transaction
// either stores rx_byte (func 0) or pops the oldest byte (func 1), and yields
// exactly one result transaction. When a byte arrives while the fill count is
// above high_water, the sender is paused by dropping RTS (flow_mode 0) or by
// sending XOFF with that byte's result (flow_mode 1); a read of an empty FIFO
// while paused resumes it by raising RTS or sending XON. A byte that arrives
// while the FIFO is full is dropped and flagged. A transaction is accepted in
// idle, which updates pointers and flags and issues the single memory access;
// the registered memory read is then loaded into the output register once it
// is free or being emptied. The output register lets the next transaction be
// accepted while a result waits to be taken. Configuration is to be written
// through cfg_we, cfg_index and cfg_data only while idle (not enforced).
module rx_ring_buffer_flow_control_top #(
    parameter int DEPTH = 128
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [rrb_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [rrb_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            func,
    input  logic [7:0]                      rx_byte,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [7:0]                      read_data,
    output logic                            read_valid,
    output logic                            rx_dropped,
    output logic                            rts_level,
    output logic                            send_char_valid,
    output logic [7:0]                      send_char
);
    import rrb_pkg::*;

    rrb_cmd_t    cmd;
    rrb_status_t status;

    // Sequencer.
    rrb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Storage, pointers, flow control and output register.
    rrb_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .func            (func),
        .rx_byte         (rx_byte),
        .out_ready       (out_ready),
        .cmd             (cmd),
        .status          (status),
        .out_valid       (out_valid),
        .read_data       (read_data),
        .read_valid      (read_valid),
        .rx_dropped      (rx_dropped),
        .rts_level       (rts_level),
        .send_char_valid (send_char_valid),
        .send_char       (send_char)
    );

endmodule
